>>> rtl/accumulator_cpu_execute_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the accumulator execute unit
// Concurrent assertion helpers that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef ACCUMULATOR_CPU_EXECUTE_UNIT_MACROS_SVH
`define ACCUMULATOR_CPU_EXECUTE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define ACU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: ante implies cons");
// Next-cycle implication.
`define ACU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: ante implies cons one cycle later");
`else
`define ACU_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ACU_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> rtl/acu_pkg.sv
// ----------------------------------------------------------------------------
// Accumulator execute unit package
// Operation codes, decoded operation classes and payload structs.
// ----------------------------------------------------------------------------
package acu_pkg;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned ADDR_W = 8;
    localparam int unsigned OPC_W  = 4;
    localparam int unsigned MEM_DEPTH = 256;

    // Operation codes as they arrive on the input channel.
    localparam logic [OPC_W-1:0] OP_NOP     = 4'd0;
    localparam logic [OPC_W-1:0] OP_LOAD    = 4'd1;
    localparam logic [OPC_W-1:0] OP_STORE   = 4'd2;
    localparam logic [OPC_W-1:0] OP_ADD     = 4'd3;
    localparam logic [OPC_W-1:0] OP_JUMP    = 4'd4;
    localparam logic [OPC_W-1:0] OP_JUMPN   = 4'd5;
    localparam logic [OPC_W-1:0] OP_JUMPZ   = 4'd6;
    localparam logic [OPC_W-1:0] OP_HALT    = 4'd7;
    localparam logic [OPC_W-1:0] OP_PRELOAD = 4'd8;

    // Operation class after decode; unused codes fold into EX_NOP.
    typedef enum logic [3:0] {
        EX_NOP,
        EX_LOAD,
        EX_STORE,
        EX_ADD,
        EX_JUMP,
        EX_JUMPN,
        EX_JUMPZ,
        EX_HALT,
        EX_PRELOAD
    } exec_op_t;

    typedef enum logic {
        BK_ISSUE,
        BK_EXEC
    } back_state_t;

    typedef struct packed {
        logic [OPC_W-1:0]  operation;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] preload_data;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0] accumulator_value;
        logic              zero_status;
        logic              negative_status;
        logic              jump_taken;
        logic [ADDR_W-1:0] jump_target;
        logic              halted_status;
    } result_t;

    typedef struct packed {
        exec_op_t          op;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
    } queue_item_t;

endpackage

>>> rtl/acu_front.sv
// ----------------------------------------------------------------------------
// Accumulator execute unit front end
// Registers incoming items and decodes the operation code into a class.
// ----------------------------------------------------------------------------
module acu_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  acu_pkg::item_t       s_payload,
    output logic                 push_valid,
    input  logic                 push_ready,
    output acu_pkg::queue_item_t push_item
);

    logic                 valid_reg;
    logic                 valid_next;
    acu_pkg::queue_item_t item_reg;
    acu_pkg::exec_op_t    op_dec;
    logic                 s_xfer;

    always_comb begin
        case (s_payload.operation)
            acu_pkg::OP_NOP:     op_dec = acu_pkg::EX_NOP;
            acu_pkg::OP_LOAD:    op_dec = acu_pkg::EX_LOAD;
            acu_pkg::OP_STORE:   op_dec = acu_pkg::EX_STORE;
            acu_pkg::OP_ADD:     op_dec = acu_pkg::EX_ADD;
            acu_pkg::OP_JUMP:    op_dec = acu_pkg::EX_JUMP;
            acu_pkg::OP_JUMPN:   op_dec = acu_pkg::EX_JUMPN;
            acu_pkg::OP_JUMPZ:   op_dec = acu_pkg::EX_JUMPZ;
            acu_pkg::OP_HALT:    op_dec = acu_pkg::EX_HALT;
            acu_pkg::OP_PRELOAD: op_dec = acu_pkg::EX_PRELOAD;
            default:             op_dec = acu_pkg::EX_NOP;
        endcase
    end

    assign s_ready = !valid_reg || push_ready;
    assign s_xfer  = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (s_xfer) begin
            valid_next = 1'b1;
        end else if (push_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            item_reg.op      <= op_dec;
            item_reg.address <= s_payload.address;
            item_reg.data    <= s_payload.preload_data;
        end
    end

    assign push_valid = valid_reg;
    assign push_item  = item_reg;

endmodule

>>> rtl/acu_queue.sv
// ----------------------------------------------------------------------------
// Accumulator execute unit decoupling queue
// Small first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
`include "accumulator_cpu_execute_unit_macros.svh"

module acu_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  acu_pkg::queue_item_t push_item,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output acu_pkg::queue_item_t pop_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    acu_pkg::queue_item_t entry_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 push;
    logic                 pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    `ACU_ASSERT_IMP(a_cnt_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DEPTH))
    `ACU_ASSERT_NXT(a_cnt_up, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + 1'b1)
    `ACU_ASSERT_IMP(a_ptr_gap, aclk, aresetn, count_reg == '0, wr_ptr_reg == rd_ptr_reg)

endmodule

>>> rtl/acu_back.sv
// ----------------------------------------------------------------------------
// Accumulator execute unit back end
// Reads the operand memory, executes the operation and holds the result.
// ----------------------------------------------------------------------------
`include "accumulator_cpu_execute_unit_macros.svh"

module acu_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  acu_pkg::queue_item_t pop_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output acu_pkg::result_t     m_payload
);

    logic [acu_pkg::DATA_W-1:0] mem [acu_pkg::MEM_DEPTH];

    acu_pkg::back_state_t       state_reg;
    acu_pkg::back_state_t       state_next;
    acu_pkg::queue_item_t       item_reg;
    logic [acu_pkg::DATA_W-1:0] rd_data_reg;
    logic [acu_pkg::DATA_W-1:0] acc_reg;
    logic [acu_pkg::DATA_W-1:0] acc_next;
    logic                       zero_reg;
    logic                       zero_next;
    logic                       neg_reg;
    logic                       neg_next;
    logic                       halt_reg;
    logic                       halt_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    acu_pkg::result_t           out_reg;
    acu_pkg::result_t           out_next;
    acu_pkg::exec_op_t          eff_op;
    logic [acu_pkg::DATA_W-1:0] acc_sum;
    logic                       taken;
    logic                       pop;
    logic                       out_load;
    logic                       mem_we;
    logic [acu_pkg::DATA_W-1:0] mem_wdata;

    assign eff_op  = (halt_reg && item_reg.op != acu_pkg::EX_PRELOAD) ? acu_pkg::EX_NOP
                                                                       : item_reg.op;
    assign acc_sum = acc_reg + rd_data_reg;

    always_comb begin
        state_next     = state_reg;
        pop            = 1'b0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !m_ready;
        acc_next       = acc_reg;
        zero_next      = zero_reg;
        neg_next       = neg_reg;
        halt_next      = halt_reg;
        taken          = 1'b0;
        mem_we         = 1'b0;
        mem_wdata      = item_reg.data;

        case (eff_op)
            acu_pkg::EX_LOAD: begin
                acc_next  = rd_data_reg;
                zero_next = (rd_data_reg == '0);
                neg_next  = rd_data_reg[acu_pkg::DATA_W-1];
            end
            acu_pkg::EX_ADD: begin
                acc_next  = acc_sum;
                zero_next = (acc_sum == '0);
                neg_next  = acc_sum[acu_pkg::DATA_W-1];
            end
            acu_pkg::EX_STORE: begin
                mem_we    = 1'b1;
                mem_wdata = acc_reg;
            end
            acu_pkg::EX_PRELOAD: begin
                mem_we = 1'b1;
            end
            acu_pkg::EX_JUMP:  taken = 1'b1;
            acu_pkg::EX_JUMPN: taken = neg_reg;
            acu_pkg::EX_JUMPZ: taken = zero_reg;
            acu_pkg::EX_HALT:  halt_next = 1'b1;
            default: begin
            end
        endcase

        out_next.accumulator_value = acc_next;
        out_next.zero_status       = zero_next;
        out_next.negative_status   = neg_next;
        out_next.jump_taken        = taken;
        out_next.jump_target       = taken ? item_reg.address : '0;
        out_next.halted_status     = halt_next;

        case (state_reg)
            acu_pkg::BK_ISSUE: begin
                mem_we = 1'b0;
                pop    = pop_valid;
                if (pop_valid) begin
                    state_next = acu_pkg::BK_EXEC;
                end
            end
            acu_pkg::BK_EXEC: begin
                if (!out_valid_reg || m_ready) begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = acu_pkg::BK_ISSUE;
                end else begin
                    mem_we = 1'b0;
                end
            end
            default: begin
                mem_we     = 1'b0;
                state_next = acu_pkg::BK_ISSUE;
            end
        endcase
    end

    assign pop_ready = pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= acu_pkg::BK_ISSUE;
            acc_reg       <= '0;
            zero_reg      <= 1'b0;
            neg_reg       <= 1'b0;
            halt_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (out_load) begin
                acc_reg  <= acc_next;
                zero_reg <= zero_next;
                neg_reg  <= neg_next;
                halt_reg <= halt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            item_reg <= pop_item;
        end
        if (out_load) begin
            out_reg <= out_next;
        end
    end

    // Operand memory: one synchronous read port, one write port.
    always_ff @(posedge aclk) begin
        if (pop) begin
            rd_data_reg <= mem[pop_item.address];
        end
        if (mem_we) begin
            mem[item_reg.address] <= mem_wdata;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

    `ACU_ASSERT_NXT(a_halt_sticky, aclk, aresetn, halt_reg, halt_reg)
    `ACU_ASSERT_IMP(a_no_target, aclk, aresetn, m_valid && !m_payload.jump_taken, m_payload.jump_target == '0)
    `ACU_ASSERT_IMP(a_flags_match, aclk, aresetn, m_valid, m_payload.zero_status == (m_payload.accumulator_value == '0) || !(item_reg.op == acu_pkg::EX_LOAD || item_reg.op == acu_pkg::EX_ADD) || halt_reg || state_reg != acu_pkg::BK_ISSUE)
    `ACU_ASSERT_IMP(a_pop_issue, aclk, aresetn, pop, state_reg == acu_pkg::BK_ISSUE && !mem_we)

endmodule

>>> rtl/accumulator_cpu_execute_unit.sv
// ----------------------------------------------------------------------------
// Accumulator CPU execute unit
// Execute stage of an 8-bit accumulator machine with a 256-byte memory.
// ----------------------------------------------------------------------------
// Usage: each transfer on the s_ channel carries one instruction (operation,
// operand address or jump target, and a data byte used only by preload).
// Every instruction yields exactly one transfer on the m_ channel with the
// accumulator, flags, jump outcome and halt state after that instruction.
// The front end decodes and registers an instruction and hands it to a
// two-entry queue, so the input keeps taking transfers while the back end
// is busy or the receiver stalls. The back end reads the operand memory
// through its registered read port in its issue state, then executes and
// loads the result register in its exec state; it does not take a new
// instruction from the queue until the last one has been executed. When
// m_ready is low the result is held and the back end waits; the queue and
// front register then fill and s_ready drops. Reset clears the accumulator,
// flags and halt state and empties the pipe; memory contents are undefined
// until written.
// ----------------------------------------------------------------------------
module accumulator_cpu_execute_unit #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  acu_pkg::item_t   s_payload,
    output logic             m_valid,
    input  logic             m_ready,
    output acu_pkg::result_t m_payload
);

    // Front end to queue.
    logic                 fq_valid;
    logic                 fq_ready;
    acu_pkg::queue_item_t fq_item;

    // Queue to back end.
    logic                 qb_valid;
    logic                 qb_ready;
    acu_pkg::queue_item_t qb_item;

    // The front end only decodes and registers, so it never has to know about memory
    // hazards; the accumulator, flags, halt state and operand memory live in the back end.
    acu_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item)
    );

    // The queue absorbs instructions while the back end works through its
    // read-then-execute sequence or waits on the receiver.
    acu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_item   (qb_item)
    );

    // The back end executes strictly in order, so a store is written before
    // the next instruction reads memory and no forwarding is needed.
    acu_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (qb_valid),
        .pop_ready (qb_ready),
        .pop_item  (qb_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule
